// File: rtl/fene_pkg.sv
package fene_pkg;

   localparam int COEFFS_PER_PAIR = 7;

   localparam logic [1:0] FUNC_LOAD = 2'd0;
   localparam logic [1:0] FUNC_PAIR = 2'd1;
   localparam logic [1:0] FUNC_BOND = 2'd2;
   localparam logic [1:0] FUNC_HARD = 2'd3;

   // coefficient slots within one type-pair entry
   localparam int SLOT_C12    = 0;
   localparam int SLOT_C6     = 1;
   localparam int SLOT_EPS    = 2;
   localparam int SLOT_CUT_SQ = 3;
   localparam int SLOT_R0_SQ  = 4;
   localparam int SLOT_K_R0SQ = 5;
   localparam int SLOT_INV_R0 = 6;

   localparam logic [47:0] E_MAX   = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] ONE_Q   = 48'h0000_0100_0000;
   localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

   // pipeline stage map
   localparam int DIV_STEPS = 47;
   localparam int ST_DIV    = 2;
   localparam int ST_M1     = ST_DIV + DIV_STEPS;
   localparam int ST_M2     = ST_M1 + 4;
   localparam int ST_M3     = ST_M2 + 4;
   localparam int ST_SUB    = ST_M3 + 4;
   localparam int ST_M4     = ST_SUB + 1;
   localparam int ST_ADD    = ST_M4 + 4;
   localparam int ST_M5     = ST_ADD + 1;
   localparam int ST_ONE    = ST_M5 + 4;
   localparam int ST_NRM    = ST_ONE + 1;
   localparam int NRM_STEPS = 6;
   localparam int ST_SQ     = ST_NRM + NRM_STEPS;
   localparam int SQ_STEPS  = 24;
   localparam int ST_L2     = ST_SQ + SQ_STEPS;
   localparam int ST_LN     = ST_L2 + 1;
   localparam int ST_SGN    = ST_LN + 1;
   localparam int ST_M6     = ST_SGN + 1;
   localparam int ST_OUT    = ST_M6 + 4;
   localparam int NST       = ST_OUT;

   typedef struct packed {
      logic [1:0]         func;
      logic [1:0]         type_a;
      logic [1:0]         type_b;
      logic [2:0]         coeff_slot;
      logic signed [47:0] coeff_value;
      logic [46:0]        dist_sq;
   } req_type;

   typedef struct packed {
      logic signed [47:0] energy;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic        neg;
      logic [47:0] ma;
      logic [47:0] mb;
      logic [47:0] hh;
      logic [47:0] ll;
      logic [47:0] hl;
      logic [47:0] lh;
   } mul_type;

   typedef struct packed {
      logic        ov;
      logic [47:0] val;
   } mul_res_type;

   typedef struct packed {
      logic        vld;
      logic [1:0]  func;
      logic        tok;
      logic [46:0] d;
      logic [47:0] c0;
      logic [47:0] c1;
      logic [47:0] c2;
      logic [47:0] c5;
      logic [47:0] c6;
      logic        skip;
      logic        ov_p;
      logic        ov_b;
      logic [46:0] rr;
      logic [46:0] q;
      logic [47:0] p;
      logic [47:0] mr;
      logic [47:0] t;
      logic [47:0] e;
      mul_type     m;
      logic [47:0] v;
      logic [5:0]  lz;
      logic [30:0] y;
      logic [23:0] frac;
      logic        lneg;
      logic [28:0] l2m;
      logic [47:0] lnv;
   } stage_type;

   function automatic logic [47:0] mag48(logic [47:0] a);
      mag48 = a[47] ? (~a + 48'd1) : a;
   endfunction

   function automatic mul_type mul_a(logic [47:0] a, logic [47:0] b);
      mul_type m;
      m     = '0;
      m.neg = a[47] ^ b[47];
      m.ma  = mag48(a);
      m.mb  = mag48(b);
      return m;
   endfunction

   function automatic mul_type mul_b(mul_type s);
      mul_type m;
      m    = s;
      m.hh = s.ma[47:24] * s.mb[47:24];
      m.ll = s.ma[23:0] * s.mb[23:0];
      return m;
   endfunction

   function automatic mul_type mul_c(mul_type s);
      mul_type m;
      m    = s;
      m.hl = s.ma[47:24] * s.mb[23:0];
      m.lh = s.ma[23:0] * s.mb[47:24];
      return m;
   endfunction

   function automatic mul_res_type mul_d(mul_type s);
      mul_res_type res;
      logic [50:0] r;
      logic [50:0] lim;
      r = 51'({s.hh[22:0], 24'd0}) + 51'(s.hl) + 51'(s.lh) + 51'(s.ll[47:24]);
      lim = s.neg ? 51'h0_8000_0000_0000 : 51'h0_7FFF_FFFF_FFFF;
      res.ov  = (|s.hh[47:23]) | (r > lim);
      res.val = s.neg ? (~r[47:0] + 48'd1) : r[47:0];
      return res;
   endfunction

   // one pipeline stage; k is fixed per instance
   function automatic stage_type stage_step(int k, stage_type s);
      stage_type   n;
      logic [47:0] r2;
      logic [48:0] w;
      logic [30:0] y0;
      logic [61:0] sq;
      logic [31:0] yy;
      logic [5:0]  ex;
      logic [29:0] l2;
      logic [60:0] prod;
      mul_res_type mres;
      int          sh;
      n = s;
      if (k >= ST_DIV && k < ST_DIV + DIV_STEPS) begin
         r2 = {s.rr, 1'b0};
         if (r2 >= {1'b0, s.d}) begin
            n.rr = 47'(r2 - {1'b0, s.d});
            n.q[6'(ST_DIV + DIV_STEPS - 1 - k)] = 1'b1;
         end else begin
            n.rr = r2[46:0];
         end
      end else if (k == ST_M1) begin
         n.p = {1'b0, s.q};
         n.m = mul_a({1'b0, s.q}, {1'b0, s.q});
      end else if (k == ST_M2) begin
         n.m = mul_a(s.mr, s.p);
      end else if (k == ST_M3) begin
         // hold p6 for the second product
         n.p = s.mr;
         n.m = mul_a(s.mr, (s.func == FUNC_HARD) ? s.mr : s.c0);
      end else if (k == ST_M4) begin
         n.m = (s.func == FUNC_HARD) ? mul_a(s.t, s.c0) : mul_a(s.p, s.t);
      end else if (k == ST_M5) begin
         n.m = mul_a({1'b0, s.d}, s.c6);
      end else if (k == ST_M6) begin
         n.m = mul_a(s.c5, s.lnv);
      end else if (k == ST_M1 + 1 || k == ST_M2 + 1 || k == ST_M3 + 1 ||
                   k == ST_M4 + 1 || k == ST_M5 + 1 || k == ST_M6 + 1) begin
         n.m = mul_b(s.m);
      end else if (k == ST_M1 + 2 || k == ST_M2 + 2 || k == ST_M3 + 2 ||
                   k == ST_M4 + 2 || k == ST_M5 + 2 || k == ST_M6 + 2) begin
         n.m = mul_c(s.m);
      end else if (k == ST_M1 + 3 || k == ST_M2 + 3 || k == ST_M3 + 3 ||
                   k == ST_M4 + 3) begin
         mres   = mul_d(s.m);
         n.mr   = mres.val;
         n.ov_p = s.ov_p | mres.ov;
      end else if (k == ST_M5 + 3 || k == ST_M6 + 3) begin
         mres   = mul_d(s.m);
         n.mr   = mres.val;
         n.ov_b = s.ov_b | mres.ov;
      end else if (k == ST_SUB) begin
         if (s.func == FUNC_HARD) begin
            n.t = s.mr;
         end else begin
            w    = {s.mr[47], s.mr} - {s.c1[47], s.c1};
            n.t  = w[47:0];
            n.ov_p = s.ov_p | (w[48] ^ w[47]);
         end
      end else if (k == ST_ADD) begin
         if (s.func == FUNC_HARD) begin
            n.e = s.mr;
         end else begin
            w    = {s.mr[47], s.mr} + {s.c2[47], s.c2};
            n.e  = w[47:0];
            n.ov_p = s.ov_p | (w[48] ^ w[47]);
         end
      end else if (k == ST_ONE) begin
         w      = {ONE_Q[47], ONE_Q} - {s.mr[47], s.mr};
         n.t    = w[47:0];
         n.v    = w[47:0];
         n.lz   = '0;
         n.ov_b = s.ov_b | (w[48] ^ w[47]) | ($signed(w) <= 49'sd0);
      end else if (k >= ST_NRM && k < ST_NRM + NRM_STEPS) begin
         // left-justify: shifts of 32, 16, 8, 4, 2, 1
         sh = 32 >> (k - ST_NRM);
         if ((s.v >> (48 - sh)) == 48'd0) begin
            n.v  = s.v << sh;
            n.lz = s.lz + 6'(sh);
         end
      end else if (k >= ST_SQ && k < ST_SQ + SQ_STEPS) begin
         y0 = (k == ST_SQ) ? s.v[47:17] : s.y;
         sq = 62'(y0) * 62'(y0);
         yy = sq[61:30];
         n.frac = {s.frac[22:0], yy[31]};
         n.y    = yy[31] ? yy[31:1] : yy[30:0];
      end else if (k == ST_L2) begin
         ex     = 6'(7'd23 - {1'b0, s.lz});
         l2     = {ex, s.frac};
         n.lneg = l2[29];
         n.l2m  = l2[29] ? 29'(~l2 + 30'd1) : l2[28:0];
      end else if (k == ST_LN) begin
         prod  = 61'(s.l2m) * 61'(LN2_Q32);
         n.l2m = prod[60:32];
      end else if (k == ST_SGN) begin
         n.lnv = s.lneg ? (~48'(s.l2m) + 48'd1) : 48'(s.l2m);
      end else if (k == ST_OUT) begin
         case (s.func)
            FUNC_PAIR: begin
               n.ov_p = s.skip ? 1'b0 : s.ov_p;
               n.e    = s.skip ? 48'd0 : s.e;
            end
            FUNC_HARD: begin
               n.ov_p = s.ov_p;
               n.e    = s.e;
            end
            FUNC_BOND: begin
               n.ov_p = s.ov_b;
               n.e    = s.mr;
            end
            default: begin
               n.ov_p = 1'b0;
               n.e    = 48'd0;
            end
         endcase
         if (n.ov_p) begin
            n.e = E_MAX;
         end
      end
      return n;
   endfunction

endpackage

// File: rtl/fene_wca_pair_energy_unit.sv
// A result strobes at the end of the pipeline, which includes one table read stage,
// 47 reciprocal steps, six 4-stage multiplies and 24 log squarings.
// Throughput: one word per cycle; busy stays low, the receiver cannot stall and
// loads give no result.
// Reset clears the pipeline valid bits only; the coefficient table holds
// garbage until software loads it.
module fene_wca_pair_energy_unit
   import fene_pkg::*;
#(
   parameter int NUM_TYPES = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int NUM_PAIRS = NUM_TYPES * NUM_TYPES;
   localparam int PAIR_AW   = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;

   logic [47:0]        coef_mem [COEFFS_PER_PAIR][NUM_PAIRS];
   logic [47:0]        coef_rd_ff [COEFFS_PER_PAIR];
   logic [PAIR_AW-1:0] pair_addr;
   logic               type_ok;
   logic               accept;
   logic               load_we;

   stage_type pipe_ff [NST+1];
   stage_type pipe_in [NST+1];
   stage_type entry_in;
   stage_type init_in;

   // drop the valid bit while reset is high
   function automatic stage_type gate_vld(stage_type s, logic clr);
      gate_vld     = s;
      gate_vld.vld = s.vld && !clr;
   endfunction

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign type_ok   = (int'(req_data.type_a) < NUM_TYPES) &&
                      (int'(req_data.type_b) < NUM_TYPES);
   assign pair_addr = PAIR_AW'(int'(req_data.type_a) * NUM_TYPES + int'(req_data.type_b));
   assign load_we   = accept && (req_data.func == FUNC_LOAD) && type_ok;

   // one small memory per slot, written and read at the word's type pair
   always_ff @(posedge clock) begin
      for (int j = 0; j < COEFFS_PER_PAIR; j++) begin
         if (load_we && req_data.coeff_slot == 3'(j)) begin
            coef_mem[j][pair_addr] <= req_data.coeff_value;
         end
         coef_rd_ff[j] <= coef_mem[j][pair_addr];
      end
   end

   always_comb begin
      entry_in      = '0;
      entry_in.vld  = accept && (req_data.func != FUNC_LOAD);
      entry_in.func = req_data.func;
      entry_in.tok  = type_ok;
      entry_in.d    = req_data.dist_sq;
   end

   always_comb begin
      logic [47:0] ds;
      logic [47:0] c3;
      logic [47:0] c4;
      ds = {1'b0, pipe_ff[0].d};
      c3 = pipe_ff[0].tok ? coef_rd_ff[SLOT_CUT_SQ] : 48'd0;
      c4 = pipe_ff[0].tok ? coef_rd_ff[SLOT_R0_SQ] : 48'd0;
      init_in      = pipe_ff[0];
      init_in.c0   = pipe_ff[0].tok ? coef_rd_ff[SLOT_C12] : 48'd0;
      init_in.c1   = pipe_ff[0].tok ? coef_rd_ff[SLOT_C6] : 48'd0;
      init_in.c2   = pipe_ff[0].tok ? coef_rd_ff[SLOT_EPS] : 48'd0;
      init_in.c5   = pipe_ff[0].tok ? coef_rd_ff[SLOT_K_R0SQ] : 48'd0;
      init_in.c6   = pipe_ff[0].tok ? coef_rd_ff[SLOT_INV_R0] : 48'd0;
      init_in.skip = !($signed(ds) < $signed(c3));
      init_in.ov_b = !($signed(ds) < $signed(c4));
      // reciprocal overflows for a distance of two or less
      init_in.ov_p = (pipe_ff[0].d <= 47'd2);
      init_in.rr   = 47'd2;
      init_in.q    = '0;
   end

   assign pipe_in[0] = entry_in;
   assign pipe_in[1] = init_in;

   for (genvar k = 2; k <= NST; k++) begin : g_stage
      assign pipe_in[k] = stage_step(k, pipe_ff[k-1]);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= NST; k++) begin
         pipe_ff[k] <= gate_vld(pipe_in[k], reset);
      end
   end

   assign rsp_strobe         = pipe_ff[NST].vld;
   assign rsp_data.energy    = pipe_ff[NST].e;
   assign rsp_data.saturated = pipe_ff[NST].ov_p;

   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.saturated |-> rsp_data.energy == E_MAX)
      else $error("saturated result without maximum energy");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.func == FUNC_LOAD |=> !pipe_ff[0].vld)
      else $error("load word entered the pipeline");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.func != FUNC_LOAD |-> ##(NST+1) rsp_strobe)
      else $error("evaluation word lost in the pipeline");

endmodule

// File: sim/fene_pair_energy_checker.sv
`timescale 1ns / 1ps

module fene_pair_energy_checker
   import fene_pkg::*;
#(
   parameter int NUM_TYPES = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   output int      errors,
   output int      pending
);

   localparam longint EN_MAX = (longint'(1) <<< 47) - 1;
   localparam longint EN_MIN = -(longint'(1) <<< 47);
   localparam longint Q_ONE  = longint'(1) <<< 24;

   longint  coeffs [NUM_TYPES*NUM_TYPES*COEFFS_PER_PAIR];
   rsp_type energy_queue [$];

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   function automatic longint q_mul(longint a, longint b, inout bit ov);
      longint unsigned ma;
      longint unsigned mb;
      logic [127:0]    full;
      logic [127:0]    lim;
      bit              neg;
      ma   = magnitude(a);
      mb   = magnitude(b);
      neg  = (a < 0) != (b < 0);
      if (((ma >> 24) * (mb >> 24)) >= (64'd1 << 23)) begin
         ov = 1'b1;
         return 0;
      end
      full = (128'(ma) * 128'(mb)) >> 24;
      lim  = neg ? (128'd1 << 47) : 128'(EN_MAX);
      if (full > lim) begin
         ov = 1'b1;
         return 0;
      end
      return neg ? -longint'(full[63:0]) : longint'(full[63:0]);
   endfunction

   function automatic longint q_clip(longint v, inout bit ov);
      if (v > EN_MAX || v < EN_MIN) begin
         ov = 1'b1;
         return 0;
      end
      return v;
   endfunction

   function automatic longint q_recip(longint unsigned d, inout bit ov);
      longint unsigned q;
      if (d == 0) begin
         ov = 1'b1;
         return 0;
      end
      q = (64'd1 << 48) / d;
      if (q > EN_MAX) begin
         ov = 1'b1;
         return 0;
      end
      return longint'(q);
   endfunction

   // natural log of a positive Q24.24 value, bit-serial log2 then scale by ln 2
   function automatic longint q_ln(longint x);
      longint unsigned u;
      longint unsigned y;
      longint unsigned frac;
      longint unsigned r;
      longint          l2;
      int              m;
      u    = x;
      m    = 0;
      frac = 0;
      for (longint unsigned t = u; t > 1; t >>= 1)
         m++;
      y = (m >= 30) ? (u >> (m - 30)) : (u << (30 - m));
      for (int i = 0; i < 24; i++) begin
         y    = (y * y) >> 30;
         frac = frac << 1;
         if (y >= (64'd2 << 30)) begin
            y    = y >> 1;
            frac = frac | 1;
         end
      end
      l2 = (longint'(m) - 24) * Q_ONE + longint'(frac);
      r  = (magnitude(l2) * 64'hB172_17F8) >> 32;
      return (l2 < 0) ? -longint'(r) : longint'(r);
   endfunction

   function automatic bit types_ok(req_type w);
      return (int'(w.type_a) < NUM_TYPES) && (int'(w.type_b) < NUM_TYPES);
   endfunction

   // unknown types read as zero coefficients
   function automatic longint coeff_of(req_type w, int slot);
      if (!types_ok(w))
         return 0;
      return coeffs[(int'(w.type_a) * NUM_TYPES + int'(w.type_b)) * COEFFS_PER_PAIR + slot];
   endfunction

   // update the table on a load, otherwise work out the energy
   function automatic bit predict_word(req_type w, output rsp_type r);
      longint d;
      longint e;
      longint p2;
      longint p6;
      longint t;
      bit     ov;
      d  = longint'(w.dist_sq);
      e  = 0;
      ov = 1'b0;
      r  = '0;
      if (w.func == FUNC_LOAD) begin
         if (w.coeff_slot < COEFFS_PER_PAIR && types_ok(w))
            coeffs[(int'(w.type_a) * NUM_TYPES + int'(w.type_b)) * COEFFS_PER_PAIR +
                   int'(w.coeff_slot)] = longint'(w.coeff_value);
         return 1'b0;
      end
      if (w.func == FUNC_PAIR) begin
         if (d < coeff_of(w, SLOT_CUT_SQ)) begin
            p2 = q_recip(d, ov);
            p6 = q_mul(q_mul(p2, p2, ov), p2, ov);
            t  = q_clip(q_mul(p6, coeff_of(w, SLOT_C12), ov) - coeff_of(w, SLOT_C6), ov);
            e  = q_clip(q_mul(p6, t, ov) + coeff_of(w, SLOT_EPS), ov);
         end
      end else if (w.func == FUNC_BOND) begin
         if (d < coeff_of(w, SLOT_R0_SQ)) begin
            t = q_clip(Q_ONE - q_mul(d, coeff_of(w, SLOT_INV_R0), ov), ov);
            if (!ov && t <= 0)
               ov = 1'b1;
            if (!ov)
               e = q_mul(coeff_of(w, SLOT_K_R0SQ), q_ln(t), ov);
         end else begin
            ov = 1'b1;
         end
      end else begin
         p2 = q_recip(d, ov);
         p6 = q_mul(q_mul(p2, p2, ov), p2, ov);
         e  = q_mul(q_mul(p6, p6, ov), coeff_of(w, SLOT_C12), ov);
      end
      if (ov)
         e = EN_MAX;
      r.energy    = e[47:0];
      r.saturated = ov;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         errors = 0;
         foreach (coeffs[i])
            coeffs[i] = 0;
         energy_queue.delete();
      end else begin
         if (start && !busy) begin
            if (predict_word(req_data, exp_rsp))
               energy_queue.push_back(exp_rsp);
         end
         if (rsp_strobe) begin
            if (energy_queue.size() == 0) begin
               $display("%0t: unexpected word energy=%h saturated=%b", $time,
                        rsp_data.energy, rsp_data.saturated);
               errors++;
            end else begin
               exp_rsp = energy_queue.pop_front();
               if (rsp_data.energy !== exp_rsp.energy) begin
                  $display("%0t: energy expected %h actual %h", $time,
                           exp_rsp.energy, rsp_data.energy);
                  errors++;
               end
               if (rsp_data.saturated !== exp_rsp.saturated) begin
                  $display("%0t: saturated expected %b actual %b", $time,
                           exp_rsp.saturated, rsp_data.saturated);
                  errors++;
               end
            end
         end
      end
      pending = energy_queue.size();
   end

endmodule

// File: sim/tb_fene_wca_pair_energy_unit.sv
`timescale 1ns / 1ps

module tb_fene_wca_pair_energy_unit;
   import fene_pkg::*;

   localparam int NTYPES     = 4;
   localparam int NPAIRS     = NTYPES * NTYPES;
   localparam int CYCLE_CAP  = 200000;
   localparam int RAND_WORDS = 1210;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      errors;
   int      pending;
   int      cycles = 0;

   longint  nominal [NPAIRS][COEFFS_PER_PAIR];
   real     sig_sq [NPAIRS];

   fene_wca_pair_energy_unit #(.NUM_TYPES(NTYPES)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   fene_pair_energy_checker #(.NUM_TYPES(NTYPES)) i_checker (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data),
      .errors    (errors),
      .pending   (pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("fene_wca_pair_energy_unit regression: fail");
         $finish;
      end
   end

   function automatic longint to_q(real r);
      return longint'(r * 16777216.0);
   endfunction

   function automatic real frand(real lo, real hi);
      return lo + (hi - lo) * ($urandom_range(0, 100000) / 100000.0);
   endfunction

   // hold the word until it is taken; idle first with the given percentage
   task automatic send_word(req_type w, int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
   endtask

   task automatic load_coeff(int ta, int tb, int slot, longint value, int idle_pct);
      req_type w;
      w             = '0;
      w.func        = FUNC_LOAD;
      w.type_a      = 2'(ta);
      w.type_b      = 2'(tb);
      w.coeff_slot  = 3'(slot);
      w.coeff_value = value[47:0];
      w.dist_sq     = 47'($urandom());
      send_word(w, idle_pct);
   endtask

   task automatic eval_word(logic [1:0] fn, int ta, int tb, longint d, int idle_pct);
      req_type w;
      w             = '0;
      w.func        = fn;
      w.type_a      = 2'(ta);
      w.type_b      = 2'(tb);
      w.coeff_slot  = 3'($urandom_range(0, 7));
      w.coeff_value = 48'({$urandom(), $urandom()});
      w.dist_sq     = d[46:0];
      send_word(w, idle_pct);
   endtask

   // pick a distance that mostly lands near the interesting region of the pair
   function automatic longint pick_dist(int pair, logic [1:0] fn);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8)
         return longint'({$urandom(), $urandom()}) & ((longint'(1) <<< 47) - 1);
      if (pick < 13)
         return longint'($urandom_range(0, 300));
      if (fn == FUNC_BOND)
         return to_q(sig_sq[pair] * frand(0.3, 2.4));
      return to_q(sig_sq[pair] * frand(0.55, 1.4));
   endfunction

   initial begin
      real    eps;
      real    sig2;
      real    r0sq;
      real    kspr;
      int     ta;
      int     tb;
      int     slot;
      int     pick;
      int     idle_pct;
      int     pair;
      logic [1:0] fn;
      longint big;

      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // symmetric WCA plus FENE sets per type pair
      for (int a = 0; a < NTYPES; a++) begin
         for (int b = a; b < NTYPES; b++) begin
            eps  = frand(0.2, 3.0);
            sig2 = frand(0.7, 1.4);
            r0sq = 2.25 * sig2;
            kspr = frand(5.0, 40.0);
            for (int k = 0; k < 2; k++) begin
               pair = k ? (b * NTYPES + a) : (a * NTYPES + b);
               sig_sq[pair]                  = sig2;
               nominal[pair][SLOT_C12]       = to_q(4.0 * eps * sig2 ** 6);
               nominal[pair][SLOT_C6]        = to_q(4.0 * eps * sig2 ** 3);
               nominal[pair][SLOT_EPS]       = to_q(eps);
               nominal[pair][SLOT_CUT_SQ]    = to_q(1.2599 * sig2);
               nominal[pair][SLOT_R0_SQ]     = to_q(r0sq);
               nominal[pair][SLOT_K_R0SQ]    = to_q(-0.5 * kspr * r0sq);
               nominal[pair][SLOT_INV_R0]    = to_q(1.0 / r0sq);
            end
         end
      end
      for (int p = 0; p < NPAIRS; p++)
         for (int s = 0; s < COEFFS_PER_PAIR; s++)
            load_coeff(p / NTYPES, p % NTYPES, s, nominal[p][s], 0);

      // directed corners
      eval_word(FUNC_PAIR, 0, 0, 0, 0);
      eval_word(FUNC_HARD, 1, 2, 0, 0);
      eval_word(FUNC_HARD, 1, 2, 1, 0);
      eval_word(FUNC_PAIR, 3, 3, (longint'(1) <<< 47) - 1, 0);
      eval_word(FUNC_HARD, 3, 3, (longint'(1) <<< 47) - 1, 0);
      eval_word(FUNC_PAIR, 2, 1, nominal[9][SLOT_CUT_SQ], 0);
      eval_word(FUNC_PAIR, 2, 1, nominal[9][SLOT_CUT_SQ] - 1, 0);
      eval_word(FUNC_PAIR, 0, 3, to_q(sig_sq[3]), 0);
      eval_word(FUNC_BOND, 0, 1, nominal[1][SLOT_R0_SQ], 0);
      eval_word(FUNC_BOND, 0, 1, nominal[1][SLOT_R0_SQ] - 1, 0);
      eval_word(FUNC_BOND, 1, 1, 0, 0);
      eval_word(FUNC_BOND, 2, 2, to_q(sig_sq[10]), 0);
      eval_word(FUNC_HARD, 2, 3, to_q(sig_sq[11]), 0);
      // zero distance outside the cutoff: cutoff of zero
      load_coeff(3, 3, SLOT_CUT_SQ, 0, 0);
      eval_word(FUNC_PAIR, 3, 3, 0, 0);
      load_coeff(3, 3, SLOT_CUT_SQ, nominal[15][SLOT_CUT_SQ], 0);
      // bond argument at or below zero: large inverse R0 squared
      load_coeff(1, 2, SLOT_INV_R0, to_q(4.0), 0);
      eval_word(FUNC_BOND, 1, 2, nominal[6][SLOT_R0_SQ] / 2, 0);
      load_coeff(1, 2, SLOT_INV_R0, nominal[6][SLOT_INV_R0], 0);
      // ignored slot, extreme coefficient words
      load_coeff(0, 0, 7, -(longint'(1) <<< 47), 0);
      load_coeff(2, 0, SLOT_C12, (longint'(1) <<< 47) - 1, 0);
      eval_word(FUNC_HARD, 2, 0, to_q(1.0), 0);
      load_coeff(2, 0, SLOT_C12, -(longint'(1) <<< 47), 0);
      eval_word(FUNC_HARD, 2, 0, to_q(1.0), 0);
      load_coeff(2, 0, SLOT_C12, nominal[8][SLOT_C12], 0);

      for (int i = 0; i < RAND_WORDS; i++) begin
         case ((i * 4) / RAND_WORDS)
            0: idle_pct = 0;
            1: idle_pct = 47;
            2: idle_pct = 0;
            default: idle_pct = 6;
         endcase
         ta   = $urandom_range(0, NTYPES - 1);
         tb   = $urandom_range(0, NTYPES - 1);
         pair = ta * NTYPES + tb;
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            slot = $urandom_range(0, 99);
            if (slot < 65) begin
               slot = $urandom_range(0, COEFFS_PER_PAIR - 1);
               load_coeff(ta, tb, slot, nominal[pair][slot], idle_pct);
            end else if (slot < 88) begin
               big = longint'({$urandom(), $urandom()});
               load_coeff(ta, tb, $urandom_range(0, COEFFS_PER_PAIR - 1), big, idle_pct);
            end else begin
               load_coeff(ta, tb, 7, longint'({$urandom(), $urandom()}), idle_pct);
            end
         end else begin
            fn = (pick < 45) ? FUNC_PAIR : (pick < 75) ? FUNC_BOND : FUNC_HARD;
            eval_word(fn, ta, tb, pick_dist(pair, fn), idle_pct);
         end
      end
      @(negedge clock);
      start <= 1'b0;

      while (pending != 0)
         @(posedge clock);
      repeat (130) @(posedge clock);
      if (errors == 0)
         $display("fene_wca_pair_energy_unit regression: pass");
      else
         $display("fene_wca_pair_energy_unit regression: fail");
      $finish;
   end

endmodule

// File: sim.f
rtl/fene_pkg.sv
rtl/fene_wca_pair_energy_unit.sv
sim/fene_pair_energy_checker.sv
sim/tb_fene_wca_pair_energy_unit.sv
